FILE: hw/rtl/mrr_pkg.sv
// Package with the shared sizes, codes, transaction types and slot helpers of the scheduler.
package mrr_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int LEVEL_COUNT = 5;

    localparam int POS_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LEN_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int LVL_W   = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
    localparam int SLOTS   = LEVEL_COUNT * QUEUE_DEPTH;
    localparam int ADDR_W  = $clog2(SLOTS);
    localparam int TOTAL_W = $clog2(SLOTS + 1);
    localparam int SUM_W   = LEN_W + 2;

    localparam logic [1:0] REQ_ENQUEUE = 2'd0;
    localparam logic [1:0] REQ_REMOVE  = 2'd1;
    localparam logic [1:0] REQ_SELECT  = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_INVALID   = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] task_id;
        logic [2:0] task_priority;
        logic       task_ready;
        logic       ignore_state;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       selected_valid;
        logic [7:0] selected_id;
        logic [6:0] total_count;
    } res_t;

    typedef struct packed {
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic [ID_BITS-1:0] wr_data;
        logic               rd_en;
        logic [ADDR_W-1:0]  rd_addr;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_COPY,
        ST_SELECT,
        ST_DONE
    } state_t;

    // Ring position base + off, where off stays below twice the depth.
    function automatic logic [POS_W-1:0] pos_wrap(logic [POS_W-1:0] base,
                                                  logic [LEN_W:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= SUM_W'(QUEUE_DEPTH)) begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        if (s >= SUM_W'(QUEUE_DEPTH)) begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return POS_W'(s);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(logic [LVL_W-1:0] lvl,
                                                    logic [POS_W-1:0] pos);
        return ADDR_W'(ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(pos));
    endfunction

endpackage

FILE: hw/rtl/mrr_slot_ram.sv
// Slot memory holding the task ids of all ring queues, one write and one registered read port.
module mrr_slot_ram (
    input  logic                        aclk,
    input  mrr_pkg::mem_req_t           mem_req,
    output logic [mrr_pkg::ID_BITS-1:0] rd_data
);

    logic [mrr_pkg::ID_BITS-1:0] mem [mrr_pkg::SLOTS];

    always_ff @(posedge aclk) begin
        if (mem_req.wr_en) begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_req.rd_en) begin
            rd_data <= mem[mem_req.rd_addr];
        end
    end

endmodule

FILE: hw/rtl/mrr_ctrl.sv
// Sequencer that runs enqueue, remove and select against the slot memory and the queue pointers.
module mrr_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  mrr_pkg::req_t               s_data,
    output logic                        res_valid,
    input  logic                        res_ready,
    output mrr_pkg::res_t               result,
    output mrr_pkg::mem_req_t           mem_req,
    input  logic [mrr_pkg::ID_BITS-1:0] rd_data
);

    localparam int POS_W = mrr_pkg::POS_W;
    localparam int LEN_W = mrr_pkg::LEN_W;
    localparam int LVL_W = mrr_pkg::LVL_W;
    localparam int LVLS  = mrr_pkg::LEVEL_COUNT;

    mrr_pkg::state_t state_reg, state_next;
    mrr_pkg::req_t   req_reg, req_next;

    logic [POS_W-1:0] heads_reg [LVLS];
    logic [POS_W-1:0] heads_next [LVLS];
    logic [LEN_W-1:0] lens_reg [LVLS];
    logic [LEN_W-1:0] lens_next [LVLS];

    logic [LVL_W-1:0]            lvl_reg, lvl_next;
    logic [LEN_W-1:0]            idx_reg, idx_next;
    logic [LEN_W-1:0]            k_reg, k_next;
    logic [1:0]                  status_reg, status_next;
    logic                        sel_valid_reg, sel_valid_next;
    logic [mrr_pkg::ID_BITS-1:0] sel_id_reg, sel_id_next;
    logic [mrr_pkg::TOTAL_W-1:0] total_reg, total_next;

    logic                        prio_ok, chk_enq, chk_rem;
    logic [LVL_W-1:0]            lvl_in, sel_lvl, disp_lvl, cur_lvl;
    logic                        sel_found;
    logic [POS_W-1:0]            cur_head;
    logic [LEN_W-1:0]            cur_len;
    logic [mrr_pkg::ID_BITS-1:0] cur_id;
    logic                        scan_match, scan_last, copy_last, disp_scan;
    logic [LEN_W:0]              idx_plus1;

    assign prio_ok = (req_reg.task_priority != 3'd0) &&
                     ({1'b0, req_reg.task_priority} <= 4'(LVLS));
    assign lvl_in  = LVL_W'(req_reg.task_priority - 3'd1);
    assign chk_enq = prio_ok && (req_reg.task_ready || req_reg.ignore_state);
    assign chk_rem = prio_ok && (!req_reg.task_ready || req_reg.ignore_state);
    assign cur_id  = mrr_pkg::ID_BITS'(req_reg.task_id);

    // The highest non-empty level wins.
    always_comb begin
        sel_found = 1'b0;
        sel_lvl   = '0;
        for (int l = 0; l < LVLS; l++) begin
            if (lens_reg[l] != '0) begin
                sel_found = 1'b1;
                sel_lvl   = LVL_W'(l);
            end
        end
    end

    assign disp_lvl = (req_reg.req_type == mrr_pkg::REQ_SELECT) ? sel_lvl : lvl_in;
    assign cur_lvl  = (state_reg == mrr_pkg::ST_DISPATCH) ? disp_lvl : lvl_reg;
    assign cur_head = heads_reg[cur_lvl];
    assign cur_len  = lens_reg[cur_lvl];

    assign idx_plus1  = {1'b0, idx_reg} + (LEN_W + 1)'(1);
    assign scan_match = (rd_data == cur_id);
    assign scan_last  = (idx_plus1 == {1'b0, cur_len});
    assign copy_last  = (idx_plus1 == {1'b0, k_reg});
    assign disp_scan  = chk_rem && (cur_len != '0);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mrr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = mrr_pkg::ST_DISPATCH;
                end
            end
            mrr_pkg::ST_DISPATCH: begin
                state_next = mrr_pkg::ST_DONE;
                if ((req_reg.req_type == mrr_pkg::REQ_REMOVE) && disp_scan) begin
                    state_next = mrr_pkg::ST_SCAN;
                end
                if ((req_reg.req_type == mrr_pkg::REQ_SELECT) && sel_found) begin
                    state_next = mrr_pkg::ST_SELECT;
                end
            end
            mrr_pkg::ST_SCAN: begin
                if (scan_match) begin
                    state_next = (idx_reg == '0) ? mrr_pkg::ST_DONE : mrr_pkg::ST_COPY;
                end else if (scan_last) begin
                    state_next = mrr_pkg::ST_DONE;
                end
            end
            mrr_pkg::ST_COPY: begin
                if (copy_last) begin
                    state_next = mrr_pkg::ST_DONE;
                end
            end
            mrr_pkg::ST_SELECT: begin
                state_next = mrr_pkg::ST_DONE;
            end
            mrr_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = mrr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mrr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        req_next       = req_reg;
        heads_next     = heads_reg;
        lens_next      = lens_reg;
        lvl_next       = lvl_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        status_next    = status_reg;
        sel_valid_next = sel_valid_reg;
        sel_id_next    = sel_id_reg;
        total_next     = total_reg;
        mem_req        = '0;
        s_ready        = 1'b0;
        res_valid      = 1'b0;

        case (state_reg)
            mrr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next = s_data;
                end
            end
            mrr_pkg::ST_DISPATCH: begin
                lvl_next       = disp_lvl;
                sel_valid_next = 1'b0;
                sel_id_next    = '0;
                status_next    = mrr_pkg::STATUS_INVALID;
                idx_next       = '0;
                case (req_reg.req_type)
                    mrr_pkg::REQ_ENQUEUE: begin
                        if (chk_enq) begin
                            if (cur_len == LEN_W'(mrr_pkg::QUEUE_DEPTH)) begin
                                status_next = mrr_pkg::STATUS_FULL;
                            end else begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = mrr_pkg::slot_addr(disp_lvl,
                                    mrr_pkg::pos_wrap(cur_head, {1'b0, cur_len}));
                                mem_req.wr_data = cur_id;
                                lens_next[disp_lvl] = cur_len + LEN_W'(1);
                                total_next  = total_reg + mrr_pkg::TOTAL_W'(1);
                                status_next = mrr_pkg::STATUS_OK;
                            end
                        end
                    end
                    mrr_pkg::REQ_REMOVE: begin
                        if (chk_rem) begin
                            if (cur_len == '0) begin
                                status_next = mrr_pkg::STATUS_NOT_FOUND;
                            end else begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = mrr_pkg::slot_addr(disp_lvl, cur_head);
                            end
                        end
                    end
                    mrr_pkg::REQ_SELECT: begin
                        if (sel_found) begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = mrr_pkg::slot_addr(disp_lvl, cur_head);
                        end else begin
                            status_next = mrr_pkg::STATUS_NOT_FOUND;
                        end
                    end
                    default: begin
                        status_next = mrr_pkg::STATUS_INVALID;
                    end
                endcase
            end
            mrr_pkg::ST_SCAN: begin
                // The read data is entry idx of the level; the next read is issued ahead.
                if (scan_match) begin
                    k_next = idx_reg;
                    if (idx_reg == '0) begin
                        heads_next[lvl_reg] = mrr_pkg::pos_wrap(cur_head, (LEN_W + 1)'(1));
                        lens_next[lvl_reg]  = cur_len - LEN_W'(1);
                        total_next  = total_reg - mrr_pkg::TOTAL_W'(1);
                        status_next = mrr_pkg::STATUS_OK;
                    end else begin
                        idx_next        = '0;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = mrr_pkg::slot_addr(lvl_reg, cur_head);
                    end
                end else if (scan_last) begin
                    status_next = mrr_pkg::STATUS_NOT_FOUND;
                end else begin
                    idx_next        = LEN_W'(idx_plus1);
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = mrr_pkg::slot_addr(lvl_reg,
                        mrr_pkg::pos_wrap(cur_head, idx_plus1));
                end
            end
            mrr_pkg::ST_COPY: begin
                // Entries ahead of the match move, in order, behind the tail.
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = mrr_pkg::slot_addr(lvl_reg,
                    mrr_pkg::pos_wrap(cur_head, {1'b0, cur_len} + {1'b0, idx_reg}));
                mem_req.wr_data = rd_data;
                if (copy_last) begin
                    heads_next[lvl_reg] = mrr_pkg::pos_wrap(cur_head,
                        {1'b0, k_reg} + (LEN_W + 1)'(1));
                    lens_next[lvl_reg]  = cur_len - LEN_W'(1);
                    total_next  = total_reg - mrr_pkg::TOTAL_W'(1);
                    status_next = mrr_pkg::STATUS_OK;
                end else begin
                    idx_next        = LEN_W'(idx_plus1);
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = mrr_pkg::slot_addr(lvl_reg,
                        mrr_pkg::pos_wrap(cur_head, idx_plus1));
                end
            end
            mrr_pkg::ST_SELECT: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = mrr_pkg::slot_addr(lvl_reg,
                    mrr_pkg::pos_wrap(cur_head, {1'b0, cur_len}));
                mem_req.wr_data = rd_data;
                heads_next[lvl_reg] = mrr_pkg::pos_wrap(cur_head, (LEN_W + 1)'(1));
                sel_valid_next = 1'b1;
                sel_id_next    = rd_data;
                status_next    = mrr_pkg::STATUS_OK;
            end
            mrr_pkg::ST_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign result.status         = status_reg;
    assign result.selected_valid = sel_valid_reg;
    assign result.selected_id    = 8'(sel_id_reg);
    assign result.total_count    = 7'(total_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mrr_pkg::ST_IDLE;
            total_reg <= '0;
            for (int l = 0; l < LVLS; l++) begin
                heads_reg[l] <= '0;
                lens_reg[l]  <= '0;
            end
        end else begin
            state_reg  <= state_next;
            total_reg  <= total_next;
            heads_reg  <= heads_next;
            lens_reg   <= lens_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        lvl_reg       <= lvl_next;
        idx_reg       <= idx_next;
        k_reg         <= k_next;
        status_reg    <= status_next;
        sel_valid_reg <= sel_valid_next;
        sel_id_reg    <= sel_id_next;
    end

endmodule

FILE: hw/rtl/multilevel_round_robin_scheduler_core.sv
// Top level of the multilevel priority round-robin scheduler with its result register.
// An accepted request passes the dispatch state, then the select state for a select, or for a
// removal the scan of its level entry by entry and the copy of the entries ahead of the match,
// then the done state and the output register. One transaction is processed at a time, and a
// removal takes longer the deeper the id lies in its level, or the longer the level when absent.
// Reset is synchronous and active low: queue heads, lengths, the total count, the sequencer state
// and the output valid clear; the slot memory is not cleared, since only written entries are ever read.
module multilevel_round_robin_scheduler_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  mrr_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output mrr_pkg::res_t m_data
);

    // Memory request and read data between the sequencer and the slot memory.
    mrr_pkg::mem_req_t           mem_req;
    logic [mrr_pkg::ID_BITS-1:0] rd_data;

    // Finished result from the sequencer, waiting for the output register.
    logic          res_valid;
    logic          res_ready;
    mrr_pkg::res_t result;

    logic          m_valid_reg, m_valid_next;
    mrr_pkg::res_t m_data_reg, m_data_next;

    mrr_slot_ram u_ram (
        .aclk    (aclk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    mrr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .result    (result),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    // The output register separates the two sides: the sequencer hands over its result and
    // returns to accept the next transaction while this one still waits for m_ready.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: bench/multilevel_round_robin_scheduler_core_tb.sv
// Self-checking testbench for the multilevel priority round-robin scheduler core.
`timescale 1ns / 100ps

module multilevel_round_robin_scheduler_core_tb;

    // The request encoding leaves one code unused; the block must reject it.
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    localparam int RANDOM_ITEMS = 1450;
    localparam int IDLE_PCT     = 37;
    // This margin outlasts the longest removal, so it covers any
    // transaction still in flight when the last expected result has been checked.
    localparam int DRAIN_CYCLES = 2 * mrr_pkg::QUEUE_DEPTH + 8;
    localparam int CYCLE_LIMIT  = 1000000;
    // Window of cycles in which neither side ever idles, so back-to-back traffic is seen too.
    localparam int CALM_START   = 2000;
    localparam int CALM_END     = 8000;

    typedef enum int {
        FILL_LEVELS,
        DRAIN_LEVELS,
        MIXED_LOAD
    } traffic_mix_t;

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    mrr_pkg::req_t s_data  = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    mrr_pkg::res_t m_data;

    multilevel_round_robin_scheduler_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    // Transactions waiting to be offered, and results owed by the block, oldest first.
    mrr_pkg::req_t pending_reqs[$];
    mrr_pkg::res_t expected_results[$];
    mrr_pkg::res_t next_result;

    int cycle_count    = 0;
    int mismatch_count = 0;
    int req_kind_count [4] = '{default: 0};
    int status_count   [4] = '{default: 0};

    // Scheduler state as the predictor sees it: one ring of ids per priority level.
    logic [mrr_pkg::ID_BITS-1:0] ring_ids  [mrr_pkg::LEVEL_COUNT][mrr_pkg::QUEUE_DEPTH];
    int                          ring_head [mrr_pkg::LEVEL_COUNT] = '{default: 0};
    int                          ring_len  [mrr_pkg::LEVEL_COUNT] = '{default: 0};

    // Membership of each level as planned while the stimulus is built. Order does not
    // matter here; it only lets removals aim at ids that will really be queued.
    logic [7:0] plan_pool [mrr_pkg::LEVEL_COUNT][mrr_pkg::QUEUE_DEPTH];
    int         plan_len  [mrr_pkg::LEVEL_COUNT] = '{default: 0};

    // Move the head entry of a level to its tail.
    function automatic void rotate_head(int lvl);
        ring_ids[lvl][(ring_head[lvl] + ring_len[lvl]) % mrr_pkg::QUEUE_DEPTH] =
            ring_ids[lvl][ring_head[lvl]];
        ring_head[lvl] = (ring_head[lvl] + 1) % mrr_pkg::QUEUE_DEPTH;
    endfunction

    // Apply one request to the predicted scheduler state and return the result it owes.
    function automatic mrr_pkg::res_t schedule_step(mrr_pkg::req_t r);
        mrr_pkg::res_t               res;
        logic [mrr_pkg::ID_BITS-1:0] id;
        bit                          prio_ok;
        bit                          found;
        int                          lvl;
        int                          k;
        int                          total;
        res        = '0;
        res.status = mrr_pkg::STATUS_INVALID;
        id         = r.task_id[mrr_pkg::ID_BITS-1:0];
        prio_ok    = r.task_priority >= 1 && r.task_priority <= mrr_pkg::LEVEL_COUNT;
        lvl        = prio_ok ? int'(r.task_priority) - 1 : 0;
        case (r.req_type)
            mrr_pkg::REQ_ENQUEUE: begin
                // The ready check comes first, but a bad priority rejects either way.
                if ((r.task_ready || r.ignore_state) && prio_ok) begin
                    if (ring_len[lvl] >= mrr_pkg::QUEUE_DEPTH) begin
                        res.status = mrr_pkg::STATUS_FULL;
                    end else begin
                        ring_ids[lvl][(ring_head[lvl] + ring_len[lvl]) %
                                      mrr_pkg::QUEUE_DEPTH] = id;
                        ring_len[lvl]++;
                        res.status = mrr_pkg::STATUS_OK;
                    end
                end
            end
            mrr_pkg::REQ_REMOVE: begin
                if ((!r.task_ready || r.ignore_state) && prio_ok) begin
                    res.status = mrr_pkg::STATUS_NOT_FOUND;
                    found = 1'b0;
                    k     = 0;
                    while (!found && k < ring_len[lvl]) begin
                        if (ring_ids[lvl][(ring_head[lvl] + k) % mrr_pkg::QUEUE_DEPTH] == id)
                        begin
                            found = 1'b1;
                        end else begin
                            k++;
                        end
                    end
                    if (found) begin
                        // Entries ahead of the match go behind the rest, then it is dropped.
                        repeat (k) rotate_head(lvl);
                        ring_head[lvl] = (ring_head[lvl] + 1) % mrr_pkg::QUEUE_DEPTH;
                        ring_len[lvl]--;
                        res.status = mrr_pkg::STATUS_OK;
                    end
                end
            end
            mrr_pkg::REQ_SELECT: begin
                res.status = mrr_pkg::STATUS_NOT_FOUND;
                for (k = mrr_pkg::LEVEL_COUNT - 1; k >= 0; k--) begin
                    if (!res.selected_valid && ring_len[k] > 0) begin
                        res.selected_id    = 8'(ring_ids[k][ring_head[k]]);
                        res.selected_valid = 1'b1;
                        res.status         = mrr_pkg::STATUS_OK;
                        rotate_head(k);
                    end
                end
            end
            default: begin
            end
        endcase
        total = 0;
        for (k = 0; k < mrr_pkg::LEVEL_COUNT; k++) begin
            total += ring_len[k];
        end
        res.total_count = 7'(total);
        return res;
    endfunction

    // Queue one request for the driver and track what it will do to level membership.
    task automatic add_request(logic [1:0] kind, logic [7:0] id, logic [2:0] prio,
                               bit rdy, bit ign);
        int lvl;
        int i;
        bit hit;
        pending_reqs.push_back('{kind, id, prio, rdy, ign});
        if (prio >= 1 && prio <= mrr_pkg::LEVEL_COUNT) begin
            lvl = int'(prio) - 1;
            if (kind == mrr_pkg::REQ_ENQUEUE && (rdy || ign) &&
                plan_len[lvl] < mrr_pkg::QUEUE_DEPTH) begin
                plan_pool[lvl][plan_len[lvl]] = id;
                plan_len[lvl]++;
            end else if (kind == mrr_pkg::REQ_REMOVE && (!rdy || ign)) begin
                hit = 1'b0;
                for (i = 0; i < plan_len[lvl]; i++) begin
                    if (!hit && plan_pool[lvl][i] == mrr_pkg::ID_BITS'(id)) begin
                        plan_pool[lvl][i] = plan_pool[lvl][plan_len[lvl] - 1];
                        plan_len[lvl]--;
                        hit = 1'b1;
                    end
                end
            end
        end
    endtask

    task automatic note_mismatch(string msg);
        $display("[%0t] check failed: %s", $time, msg);
        mismatch_count++;
    endtask

    // Both sides idle at random, except inside the calm window.
    function automatic bit take_break();
        if (cycle_count >= CALM_START && cycle_count < CALM_END) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    // Driver. A transaction accepted at this edge is fed to the predictor right away; the
    // next one is offered only when the channel is free, so valid never drops early.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(schedule_step(s_data));
                req_kind_count[s_data.req_type]++;
            end
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() > 0 && !take_break()) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_reqs.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !take_break();
        end
    end

    // Monitor. Every result transaction is matched against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                note_mismatch($sformatf("result %h arrived with nothing expected", m_data));
            end else begin
                next_result = expected_results.pop_front();
                status_count[next_result.status]++;
                if (m_data.status !== next_result.status) begin
                    note_mismatch($sformatf("status got %0d, expected %0d",
                                            m_data.status, next_result.status));
                end
                if (m_data.selected_valid !== next_result.selected_valid) begin
                    note_mismatch($sformatf("selected_valid got %0d, expected %0d",
                                            m_data.selected_valid, next_result.selected_valid));
                end
                if (m_data.selected_id !== next_result.selected_id) begin
                    note_mismatch($sformatf("selected_id got %0d, expected %0d",
                                            m_data.selected_id, next_result.selected_id));
                end
                if (m_data.total_count !== next_result.total_count) begin
                    note_mismatch($sformatf("total_count got %0d, expected %0d",
                                            m_data.total_count, next_result.total_count));
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        traffic_mix_t mix;
        int           n;
        int           chunk_left;
        int           focus;
        int           roll;
        int           enq_pct;
        int           rem_pct;
        int           lvl;
        int           bad;
        logic [2:0]   prio;
        logic [7:0]   id;
        bit           rdy;

        // Directed part: empty select, rejected codes and priorities, ready-state checks,
        // duplicates, removal with rotation, absent ids, and draining back to empty.
        add_request(mrr_pkg::REQ_SELECT,  8'h00, 3'd0, 1'b0, 1'b0);
        add_request(REQ_UNKNOWN,          8'hff, 3'd7, 1'b1, 1'b1);
        add_request(mrr_pkg::REQ_ENQUEUE, 8'hff, 3'd5, 1'b0, 1'b0);
        add_request(mrr_pkg::REQ_ENQUEUE, 8'h11, 3'd0, 1'b1, 1'b0);
        add_request(mrr_pkg::REQ_ENQUEUE, 8'h22, 3'd6, 1'b1, 1'b1);
        add_request(mrr_pkg::REQ_ENQUEUE, 8'h00, 3'd7, 1'b1, 1'b0);
        add_request(mrr_pkg::REQ_ENQUEUE, 8'hff, 3'd5, 1'b1, 1'b0);
        add_request(mrr_pkg::REQ_ENQUEUE, 8'h00, 3'd1, 1'b0, 1'b1);
        add_request(mrr_pkg::REQ_ENQUEUE, 8'h5a, 3'd5, 1'b1, 1'b0);
        add_request(mrr_pkg::REQ_ENQUEUE, 8'hff, 3'd5, 1'b1, 1'b1);
        add_request(mrr_pkg::REQ_REMOVE,  8'hff, 3'd5, 1'b1, 1'b0);
        add_request(mrr_pkg::REQ_REMOVE,  8'h33, 3'd5, 1'b0, 1'b0);
        add_request(mrr_pkg::REQ_REMOVE,  8'h00, 3'd0, 1'b0, 1'b0);
        add_request(mrr_pkg::REQ_REMOVE,  8'h00, 3'd3, 1'b0, 1'b1);
        add_request(mrr_pkg::REQ_SELECT,  8'ha5, 3'd7, 1'b1, 1'b1);
        add_request(mrr_pkg::REQ_REMOVE,  8'hff, 3'd5, 1'b0, 1'b0);
        add_request(mrr_pkg::REQ_REMOVE,  8'hff, 3'd5, 1'b1, 1'b1);
        add_request(mrr_pkg::REQ_SELECT,  8'h00, 3'd0, 1'b0, 1'b0);
        add_request(mrr_pkg::REQ_REMOVE,  8'h5a, 3'd5, 1'b0, 1'b0);
        add_request(mrr_pkg::REQ_SELECT,  8'h00, 3'd0, 1'b0, 1'b0);
        add_request(mrr_pkg::REQ_REMOVE,  8'h00, 3'd1, 1'b0, 1'b0);
        add_request(mrr_pkg::REQ_SELECT,  8'h00, 3'd0, 1'b0, 1'b0);

        // Random part in chunks that favor filling, draining or a mix, mostly aimed at one
        // level, so queues run full, empty out, and removals hit deep positions.
        chunk_left = 0;
        mix        = MIXED_LOAD;
        focus      = 1;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (chunk_left == 0) begin
                mix        = traffic_mix_t'($urandom_range(0, 2));
                focus      = $urandom_range(1, mrr_pkg::LEVEL_COUNT);
                chunk_left = $urandom_range(30, 80);
            end
            chunk_left--;
            case (mix)
                FILL_LEVELS:  begin enq_pct = 65; rem_pct = 15; end
                DRAIN_LEVELS: begin enq_pct = 15; rem_pct = 60; end
                default:      begin enq_pct = 35; rem_pct = 30; end
            endcase
            prio = ($urandom_range(0, 99) < 60) ? 3'(focus)
                                                : 3'($urandom_range(1, mrr_pkg::LEVEL_COUNT));
            // A narrow id range half the time makes duplicates common.
            id   = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
            rdy  = 1'($urandom_range(0, 1));
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                case ($urandom_range(0, 3))
                    0: add_request(REQ_UNKNOWN, id, 3'($urandom_range(0, 7)),
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    1: add_request(mrr_pkg::REQ_ENQUEUE, id, prio, 1'b0, 1'b0);
                    2: add_request(mrr_pkg::REQ_REMOVE, id, prio, 1'b1, 1'b0);
                    default: begin
                        bad = $urandom_range(0, 2);
                        add_request($urandom_range(0, 1) ? mrr_pkg::REQ_ENQUEUE
                                                         : mrr_pkg::REQ_REMOVE, id,
                                    (bad == 0) ? 3'd0 : 3'(mrr_pkg::LEVEL_COUNT + bad),
                                    rdy, 1'($urandom_range(0, 1)));
                    end
                endcase
            end else if (roll < 5 + enq_pct) begin
                add_request(mrr_pkg::REQ_ENQUEUE, id, prio, rdy,
                            rdy ? 1'($urandom_range(0, 1)) : 1'b1);
            end else if (roll < 5 + enq_pct + rem_pct) begin
                lvl = int'(prio) - 1;
                if (plan_len[lvl] > 0 && $urandom_range(0, 99) < 85) begin
                    id = plan_pool[lvl][$urandom_range(0, plan_len[lvl] - 1)];
                end
                add_request(mrr_pkg::REQ_REMOVE, id, prio, rdy,
                            rdy ? 1'b1 : 1'($urandom_range(0, 1)));
            end else begin
                add_request(mrr_pkg::REQ_SELECT, 8'($urandom_range(0, 255)),
                            3'($urandom_range(0, 7)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every transaction to be taken, then for every result to come back.
        while (pending_reqs.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d transactions: %0d enqueue, %0d remove, %0d select, %0d unknown.",
                 req_kind_count[0] + req_kind_count[1] + req_kind_count[2] + req_kind_count[3],
                 req_kind_count[mrr_pkg::REQ_ENQUEUE], req_kind_count[mrr_pkg::REQ_REMOVE],
                 req_kind_count[mrr_pkg::REQ_SELECT], req_kind_count[REQ_UNKNOWN]);
        $display("Outcomes seen: %0d ok, %0d invalid, %0d not found, %0d full level.",
                 status_count[mrr_pkg::STATUS_OK], status_count[mrr_pkg::STATUS_INVALID],
                 status_count[mrr_pkg::STATUS_NOT_FOUND], status_count[mrr_pkg::STATUS_FULL]);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
